// File: rtl/bta_pkg.sv
`default_nettype none
package bta_pkg;

    localparam int PID_W      = 3;
    localparam int ASSIGNED_W = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_W      = 4;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK              = 3'd0,
        ST_ALREADY_WAITING = 3'd1,
        ST_NO_TICKET       = 3'd2,
        ST_OVERFLOW        = 3'd3,
        ST_ID_RANGE        = 3'd4
    } status_code_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } bta_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } bta_stat_t;

endpackage
`default_nettype wire

// File: rtl/bta_ram.sv
`default_nettype none
module bta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/bta_datapath.sv
`default_nettype none
module bta_datapath #(
    parameter int NUM_PROCS   = 8,
    parameter int TICKET_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bta_pkg::bta_cmd_t                 cmd,
    output bta_pkg::bta_stat_t                stat,
    input  logic                              cfg_wr_en,
    input  logic [bta_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                              in_action,
    input  logic [bta_pkg::PID_W-1:0]         in_pid,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bta_pkg::OUT_DATA_W-1:0]    out_data
);
    import bta_pkg::*;

    localparam int IDX_W = $clog2(NUM_PROCS);
    localparam int CNT_W = $clog2(NUM_PROCS + 1);
    localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

    logic [CFG_W-1:0]       active_count_reg;
    logic                   action_reg;
    logic [PID_W-1:0]       pid_reg;
    logic [CNT_W-1:0]       scan_idx_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [TICKET_BITS-1:0] top_reg;
    logic [TICKET_BITS-1:0] self_reg;
    logic [TICKET_BITS-1:0] min_reg;
    logic                   min_vld_reg;
    logic [IDX_W-1:0]       min_id_reg;
    logic [NUM_PROCS-1:0]   ent_vld_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;

    logic [CNT_W-1:0]       cnt;
    logic                   pid_in_range;
    logic [IDX_W-1:0]       pid_idx;
    logic                   issue;
    logic [TICKET_BITS-1:0] ram_rd_data;
    logic [TICKET_BITS-1:0] rd_ticket;
    logic                   self_hit;
    logic [TICKET_BITS-1:0] new_ticket;
    logic [TICKET_BITS-1:0] post_ticket;
    logic                   do_write;
    logic [ASSIGNED_W-1:0]  assigned;
    status_code_t           status_code;
    logic                   pick_self;
    logic                   hold_valid;
    logic [IDX_W-1:0]       hold_id;

    assign cnt = (int'(active_count_reg) > NUM_PROCS) ? CNT_W'(NUM_PROCS)
                                                      : CNT_W'(active_count_reg);
    assign pid_in_range = int'(pid_reg) < int'(cnt);
    assign pid_idx      = IDX_W'(pid_reg);
    assign issue        = cmd.scan && (scan_idx_reg < cnt);
    assign rd_ticket    = ent_vld_reg[rd_idx_reg] ? ram_rd_data : '0;
    assign self_hit     = pid_in_range && (rd_idx_reg == pid_idx);
    assign new_ticket   = top_reg + 1'b1;

    bta_ram #(
        .WIDTH (TICKET_BITS),
        .DEPTH (NUM_PROCS)
    ) u_ticket_ram (
        .clk     (clk),
        .wr_en   (cmd.commit && do_write),
        .wr_addr (pid_idx),
        .wr_data (post_ticket),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        status_code = ST_OK;
        do_write    = 1'b0;
        post_ticket = self_reg;
        assigned    = '0;
        if (!pid_in_range)
        begin
            status_code = ST_ID_RANGE;
        end
        else if (!action_reg)
        begin
            if (self_reg != '0)
            begin
                status_code = ST_ALREADY_WAITING;
            end
            else if (top_reg == TICKET_MAX)
            begin
                status_code = ST_OVERFLOW;
            end
            else
            begin
                do_write    = 1'b1;
                post_ticket = new_ticket;
                assigned    = ASSIGNED_W'(new_ticket);
            end
        end
        else
        begin
            if (self_reg == '0)
            begin
                status_code = ST_NO_TICKET;
            end
            else
            begin
                do_write    = 1'b1;
                post_ticket = '0;
            end
        end
    end

    // The scan gathered the holder among all other processes; the requester's own
    // ticket after this word is merged in here.
    always_comb
    begin
        pick_self = (post_ticket != '0) &&
                    (!min_vld_reg || (post_ticket < min_reg) ||
                     ((post_ticket == min_reg) && (pid_idx < min_id_reg)));
        hold_valid = pick_self || min_vld_reg;
        if (pick_self)
        begin
            hold_id = pid_idx;
        end
        else if (min_vld_reg)
        begin
            hold_id = min_id_reg;
        end
        else
        begin
            hold_id = '0;
        end
        out_data_next = {1'b0, status_code, hold_valid, PID_W'(hold_id), assigned};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= CFG_RESET;
            scan_idx_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            ent_vld_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                active_count_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                rd_vld_reg   <= 1'b0;
            end
            else
            begin
                rd_vld_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            if (cmd.commit && do_write)
            begin
                ent_vld_reg[pid_idx] <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= in_action;
            pid_reg     <= in_pid;
            top_reg     <= '0;
            self_reg    <= '0;
            min_reg     <= '0;
            min_vld_reg <= 1'b0;
            min_id_reg  <= '0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_ticket > top_reg)
            begin
                top_reg <= rd_ticket;
            end
            if (self_hit)
            begin
                self_reg <= rd_ticket;
            end
            else if ((rd_ticket != '0) && (!min_vld_reg || (rd_ticket < min_reg)))
            begin
                min_reg     <= rd_ticket;
                min_vld_reg <= 1'b1;
                min_id_reg  <= rd_idx_reg;
            end
        end
        if (issue)
        begin
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.commit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign stat.scan_done = (scan_idx_reg >= cnt) && !rd_vld_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

endmodule
`default_nettype wire

// File: rtl/bta_ctrl.sv
`default_nettype none
module bta_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output bta_pkg::bta_cmd_t  cmd,
    input  bta_pkg::bta_stat_t stat
);
    import bta_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/bakery_ticket_arbiter.sv
`default_nettype none
// Ticket arbiter for up to NUM_PROCS processes in the manner of the bakery lock. Each input
// word is a request or a release for one process, and each gives exactly one result word
// with the ticket assigned, the current holder (smallest nonzero ticket, lower id on a tie)
// and a status code. The time from acceptance of a word to a ready result is set by the
// serial scan of the ticket table, over the effective process count, through the single
// read port of its RAM. The next word is accepted in the cycle after the result is
// registered, so a word is not taken while the previous one is still being worked on.
// The result sits in an output register, so a new word is taken while the previous
// result waits.
module bakery_ticket_arbiter #(
    parameter int NUM_PROCS   = 8,
    parameter int TICKET_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bta_pkg::CFG_W-1:0]      cfg_wr_data,    // active_count
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bta_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // process_id, zero padding
    input  logic                           s_axis_tuser,   // action
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // assigned_ticket, holder_id, holder_valid, status, zero padding
    output logic [bta_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bta_pkg::*;

    bta_cmd_t  cmd;
    bta_stat_t stat;

    bta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bta_datapath #(
        .NUM_PROCS   (NUM_PROCS),
        .TICKET_BITS (TICKET_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_action   (s_axis_tuser),
        .in_pid      (s_axis_tdata[PID_W-1:0]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule
`default_nettype wire

// File: sim/tb_bakery_ticket_arbiter.sv
`timescale 1ns / 1ps

module tb_bakery_ticket_arbiter;

    import bta_pkg::*;

    localparam int   PROCS       = 8;
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        status_code_t           status;
        logic                   holder_valid;
        logic [PID_W-1:0]       holder_id;
        logic [ASSIGNED_W-1:0]  ticket;
    } ticket_result_t;

    class ticket_scoreboard;
        logic [7:0]       tickets [PROCS];
        logic [CFG_W-1:0] count;
        ticket_result_t   expected_q [$];
        int               errors;

        function new();
            foreach (tickets[k])
                tickets[k] = 8'd0;
            count  = CFG_RESET;
            errors = 0;
        endfunction

        function int live_count();
            return (count > PROCS) ? PROCS : int'(count);
        endfunction

        function void set_count(logic [CFG_W-1:0] value);
            count = value;
        endfunction

        function void find_holder(output logic hv, output logic [PID_W-1:0] hid);
            logic [7:0] best;
            hv   = 1'b0;
            hid  = '0;
            best = 8'd0;
            for (int k = 0; k < live_count(); k++)
                if (tickets[k] != 8'd0 && (!hv || tickets[k] < best))
                begin
                    hv   = 1'b1;
                    best = tickets[k];
                    hid  = PID_W'(k);
                end
        endfunction

        function void note_word(logic act, logic [PID_W-1:0] pid);
            ticket_result_t r;
            logic [7:0]     top;
            r        = '0;
            r.status = ST_OK;
            if (int'(pid) >= live_count())
                r.status = ST_ID_RANGE;
            else if (act == ACT_REQUEST)
            begin
                if (tickets[pid] != 8'd0)
                    r.status = ST_ALREADY_WAITING;
                else
                begin
                    top = 8'd0;
                    for (int k = 0; k < live_count(); k++)
                        if (tickets[k] > top)
                            top = tickets[k];
                    if (top == 8'hFF)
                        r.status = ST_OVERFLOW;
                    else
                    begin
                        tickets[pid] = top + 8'd1;
                        r.ticket     = top + 8'd1;
                    end
                end
            end
            else if (tickets[pid] == 8'd0)
                r.status = ST_NO_TICKET;
            else
                tickets[pid] = 8'd0;
            find_holder(r.holder_valid, r.holder_id);
            expected_q.push_back(r);
        endfunction

        task report(string field, int got, int want);
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
            errors++;
        endtask

        task check_word(logic [OUT_DATA_W-1:0] data);
            ticket_result_t want;
            if (expected_q.size() == 0)
                report("unexpected word", int'(data), -1);
            else
            begin
                want = expected_q.pop_front();
                if (data[7:0] !== want.ticket)
                    report("assigned_ticket", int'(data[7:0]), int'(want.ticket));
                if (data[10:8] !== want.holder_id)
                    report("holder_id", int'(data[10:8]), int'(want.holder_id));
                if (data[11] !== want.holder_valid)
                    report("holder_valid", int'(data[11]), int'(want.holder_valid));
                if (data[14:12] !== want.status)
                    report("status", int'(data[14:12]), int'(want.status));
                if (data[15] !== 1'b0)
                    report("padding", int'(data[15]), 0);
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    ticket_scoreboard sb;
    bit               calm;

    bakery_ticket_arbiter #(
        .NUM_PROCS   (PROCS),
        .TICKET_BITS (8)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("tb_bakery_ticket_arbiter: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
    end

    task automatic send_word(input logic act, input logic [PID_W-1:0] pid);
        begin
            if (!calm && $urandom_range(0, 99) < 25)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= act;
            s_axis_tdata  <= {{(IN_DATA_W - PID_W){1'b0}}, pid};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            sb.note_word(act, pid);
        end
    endtask

    // The block may only be reconfigured once every word in flight has come back.
    task automatic write_count(input logic [CFG_W-1:0] value);
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (sb.expected_q.size() != 0)
                @(posedge clk);
            repeat (12) @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= value;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            sb.set_count(value);
        end
    endtask

    // Mostly lock-like traffic: idle processes request and the holder releases. With
    // keep_full set the holder only leaves when every process waits, so tickets climb
    // until they overflow.
    task automatic run_traffic(input int n, input bit keep_full, input int calm_from,
                               input int calm_to);
        int               idle_ids [$];
        logic             hv;
        logic [PID_W-1:0] hid;
        begin
            for (int i = 0; i < n; i++)
            begin
                calm = (i >= calm_from) && (i < calm_to);
                idle_ids.delete();
                for (int k = 0; k < sb.live_count(); k++)
                    if (sb.tickets[k] == 8'd0)
                        idle_ids.push_back(k);
                sb.find_holder(hv, hid);
                if ($urandom_range(0, 9) == 0)
                    send_word(1'($urandom_range(0, 1)), PID_W'($urandom_range(0, 7)));
                else if (hv && (idle_ids.size() == 0 || (!keep_full && $urandom_range(0, 1))))
                    send_word(ACT_RELEASE, hid);
                else if (idle_ids.size() != 0)
                    send_word(ACT_REQUEST,
                              PID_W'(idle_ids[$urandom_range(0, idle_ids.size() - 1)]));
                else
                    send_word(ACT_REQUEST, PID_W'($urandom_range(0, 7)));
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        sb            = new();
        calm          = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_count(4'd8);
        send_word(ACT_RELEASE, 3'd0);
        send_word(ACT_REQUEST, 3'd0);
        send_word(ACT_REQUEST, 3'd0);
        send_word(ACT_REQUEST, 3'd7);
        send_word(ACT_REQUEST, 3'd3);
        send_word(ACT_RELEASE, 3'd0);
        send_word(ACT_RELEASE, 3'd7);
        send_word(ACT_RELEASE, 3'd3);
        send_word(ACT_REQUEST, 3'd5);

        // Process 5 keeps its ticket while it is outside the active range.
        write_count(4'd2);
        send_word(ACT_REQUEST, 3'd5);
        send_word(ACT_RELEASE, 3'd6);
        send_word(ACT_REQUEST, 3'd1);
        send_word(ACT_REQUEST, 3'd0);

        // Processes 1 and 5 now tie on the lowest ticket.
        write_count(4'd15);
        send_word(ACT_REQUEST, 3'd7);
        send_word(ACT_RELEASE, 3'd1);
        send_word(ACT_RELEASE, 3'd5);

        write_count(4'd0);
        send_word(ACT_REQUEST, 3'd0);
        send_word(ACT_RELEASE, 3'd3);

        write_count(4'd8);
        send_word(ACT_RELEASE, 3'd0);
        send_word(ACT_RELEASE, 3'd7);

        write_count(4'd3);
        run_traffic(520, 1'b1, 0, 0);
        write_count(4'd8);
        run_traffic(280, 1'b0, 0, 150);
        write_count(4'd15);
        run_traffic(150, 1'b0, 0, 0);
        write_count(4'd1);
        run_traffic(60, 1'b0, 0, 0);
        write_count(4'd5);
        run_traffic(190, 1'b0, 0, 0);

        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_bakery_ticket_arbiter: clean");
        else
            $display("tb_bakery_ticket_arbiter: errors");
        $finish;
    end

endmodule
